/* hdl/dcf_pkg.sv */
package dcf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX  = 3'd5;

    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] ZERO_MIN_RST = 8'd9;
    localparam logic [7:0] ZERO_MAX_RST = 8'd11;
    localparam logic [7:0] ONE_MIN_RST  = 8'd19;
    localparam logic [7:0] ONE_MAX_RST  = 8'd21;
    localparam logic [7:0] GAP_MIN_RST  = 8'd199;
    localparam logic [7:0] GAP_MAX_RST  = 8'd201;

    localparam logic [7:0] GAP_LIMIT   = 8'd250;
    localparam logic [7:0] PULSE_LIMIT = 8'd255;

    // result event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_MARKER = 3'd1;
    localparam logic [2:0] EV_BIT    = 3'd2;
    localparam logic [2:0] EV_ERROR  = 3'd3;
    localparam logic [2:0] EV_FRAME  = 3'd4;

    // frame field sequence
    localparam logic [3:0] FS_INIT    = 4'd0;
    localparam logic [3:0] FS_BULK    = 4'd1;
    localparam logic [3:0] FS_STATUS  = 4'd2;
    localparam logic [3:0] FS_MINUTE  = 4'd3;
    localparam logic [3:0] FS_HOUR    = 4'd4;
    localparam logic [3:0] FS_DOM     = 4'd5;
    localparam logic [3:0] FS_DOW     = 4'd6;
    localparam logic [3:0] FS_MONTH   = 4'd7;
    localparam logic [3:0] FS_YEAR    = 4'd8;
    localparam logic [3:0] FS_DATEPAR = 4'd9;

    localparam logic [3:0] BULK_BITS   = 4'd14;
    localparam logic [3:0] STATUS_BITS = 4'd6;
    localparam logic [3:0] MINUTE_BITS = 4'd8;
    localparam logic [3:0] HOUR_BITS   = 4'd7;
    localparam logic [3:0] DOM_BITS    = 4'd6;
    localparam logic [3:0] DOW_BITS    = 4'd3;
    localparam logic [3:0] MONTH_BITS  = 4'd5;
    localparam logic [3:0] YEAR_BITS   = 4'd8;
    localparam logic [3:0] COUNT_LIMIT = 4'd15;

    // status bit positions announcing summer and winter time
    localparam int SUMMER_BIT = 2;
    localparam int WINTER_BIT = 3;

    localparam logic [11:0] CENTURY = 12'd2000;

    // queue between classifier and frame decoder (depth a power of two)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic marker;
        logic error;
        logic valid;
        logic bit_val;
    } token_t;

    function automatic logic [7:0] bcd8(input logic [7:0] s);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = {4'd0, s[3:0]};
        hi = {4'd0, s[7:4]};
        return lo + hi * 8'd10;
    endfunction

endpackage

/* hdl/dcf_front.sv */
module dcf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                level,
    input  logic                                cfg_write_en,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output dcf_pkg::token_t                     tok,
    output logic                                tok_push,
    input  logic                                fifo_full
);
    import dcf_pkg::*;

    logic [7:0] zero_min_reg;
    logic [7:0] zero_max_reg;
    logic [7:0] one_min_reg;
    logic [7:0] one_max_reg;
    logic [7:0] gap_min_reg;
    logic [7:0] gap_max_reg;
    logic [7:0] pulse_reg;
    logic [7:0] pulse_next;
    logic [7:0] gap_reg;
    logic [7:0] gap_next;
    logic       in_zero;
    logic       in_one;
    logic       in_marker;

    assign in_stall = fifo_full;
    assign tok_push = in_valid && !fifo_full;

    assign in_zero   = (pulse_reg >= zero_min_reg) && (pulse_reg <= zero_max_reg);
    assign in_one    = (pulse_reg >= one_min_reg) && (pulse_reg <= one_max_reg);
    assign in_marker = (gap_reg >= gap_min_reg) && (gap_reg <= gap_max_reg);

    always_comb
    begin
        tok = '0;
        if (level)
        begin
            tok.marker = (pulse_reg == 8'd0) && in_marker;
        end
        else
        begin
            // bit 0 window has priority over bit 1 window
            if (in_zero)
            begin
                tok.valid = 1'b1;
            end
            else if (in_one)
            begin
                tok.valid   = 1'b1;
                tok.bit_val = 1'b1;
            end
            else
            begin
                tok.error = (pulse_reg != 8'd0);
            end
        end
    end

    always_comb
    begin
        if (level)
        begin
            pulse_next = (pulse_reg < PULSE_LIMIT) ? pulse_reg + 8'd1 : pulse_reg;
        end
        else
        begin
            pulse_next = 8'd0;
        end
        // a rising edge restarts the gap count, which then counts this tick
        if (level && (pulse_reg == 8'd0))
        begin
            gap_next = 8'd1;
        end
        else
        begin
            gap_next = (gap_reg < GAP_LIMIT) ? gap_reg + 8'd1 : gap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= '0;
            gap_reg   <= '0;
        end
        else if (tok_push)
        begin
            pulse_reg <= pulse_next;
            gap_reg   <= gap_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_min_reg <= ZERO_MIN_RST;
            zero_max_reg <= ZERO_MAX_RST;
            one_min_reg  <= ONE_MIN_RST;
            one_max_reg  <= ONE_MAX_RST;
            gap_min_reg  <= GAP_MIN_RST;
            gap_max_reg  <= GAP_MAX_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ZERO_MIN: zero_min_reg <= cfg_data;
                CFG_ZERO_MAX: zero_max_reg <= cfg_data;
                CFG_ONE_MIN:  one_min_reg  <= cfg_data;
                CFG_ONE_MAX:  one_max_reg  <= cfg_data;
                CFG_GAP_MIN:  gap_min_reg  <= cfg_data;
                CFG_GAP_MAX:  gap_max_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

/* hdl/dcf_fifo.sv */
module dcf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcf_pkg::token_t push_data,
    output logic            full,
    input  logic            pop,
    output dcf_pkg::token_t pop_data,
    output logic            empty
);
    import dcf_pkg::*;

    token_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/dcf_back.sv */
module dcf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dcf_pkg::token_t tok,
    input  logic            fifo_empty,
    output logic            tok_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      event_res,
    output logic            bit_value,
    output logic [6:0]      minute,
    output logic [5:0]      hour,
    output logic [5:0]      day,
    output logic [4:0]      month,
    output logic [11:0]     year,
    output logic            summer_time,
    output logic            in_sync
);
    import dcf_pkg::*;

    logic        valid_reg;
    logic [2:0]  event_reg;
    logic [2:0]  event_next;
    logic        bit_reg;
    logic        bit_next;
    logic        synced_reg;
    logic        synced_next;
    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [7:0]  sym_reg;
    logic [7:0]  sym_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [2:0]  dpar_reg;
    logic [2:0]  dpar_next;
    logic        skip_reg;
    logic        skip_next;
    logic        summer_reg;
    logic        summer_next;
    logic [6:0]  minute_reg;
    logic [6:0]  minute_next;
    logic [5:0]  hour_reg;
    logic [5:0]  hour_next;
    logic [5:0]  day_reg;
    logic [5:0]  day_next;
    logic [4:0]  month_reg;
    logic [4:0]  month_next;
    logic [11:0] year_reg;
    logic [11:0] year_next;

    assign tok_pop = !fifo_empty && (!valid_reg || !out_stall);

    assign out_valid   = valid_reg;
    assign event_res   = event_reg;
    assign bit_value   = bit_reg;
    assign minute      = minute_reg;
    assign hour        = hour_reg;
    assign day         = day_reg;
    assign month       = month_reg;
    assign year        = year_reg;
    assign summer_time = summer_reg;
    assign in_sync     = synced_reg;

    always_comb
    begin
        logic [3:0] fs;
        logic [7:0] sb;
        logic [3:0] sc;
        logic       par;
        logic [7:0] dec;
        logic       done;

        event_next  = EV_NONE;
        bit_next    = 1'b0;
        synced_next = synced_reg;
        state_next  = state_reg;
        sym_next    = sym_reg;
        count_next  = count_reg;
        dpar_next   = dpar_reg;
        skip_next   = skip_reg;
        summer_next = summer_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        fs   = state_reg;
        sb   = sym_reg;
        sc   = count_reg;
        par  = 1'b0;
        dec  = '0;
        done = 1'b0;

        if (tok.marker)
        begin
            synced_next = 1'b1;
            state_next  = FS_INIT;
            skip_next   = 1'b1;
            event_next  = EV_MARKER;
        end
        else if (tok.error)
        begin
            synced_next = 1'b0;
            event_next  = EV_ERROR;
        end
        else if (tok.valid && synced_reg)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                if (fs == FS_INIT)
                begin
                    fs = FS_BULK;
                    sb = '0;
                    sc = '0;
                end
                // bulk bits beyond the eighth are counted but not kept
                if (tok.bit_val && (sc < 4'd8))
                begin
                    sb[sc[2:0]] = 1'b1;
                end
                if (sc < COUNT_LIMIT)
                begin
                    sc = sc + 4'd1;
                end
                par = ^sb;
                state_next = fs;
                case (fs)
                    FS_BULK:
                    begin
                        if (sc == BULK_BITS)
                        begin
                            state_next = FS_STATUS;
                        end
                    end
                    FS_STATUS:
                    begin
                        if (sc == STATUS_BITS)
                        begin
                            if (sb[SUMMER_BIT] && !sb[WINTER_BIT])
                            begin
                                summer_next = 1'b1;
                            end
                            else if (sb[WINTER_BIT] && !sb[SUMMER_BIT])
                            begin
                                summer_next = 1'b0;
                            end
                            state_next = FS_MINUTE;
                        end
                    end
                    FS_MINUTE:
                    begin
                        if (sc == MINUTE_BITS)
                        begin
                            dec = bcd8(sb & 8'h7F);
                            minute_next = dec[6:0];
                            if (par)
                            begin
                                synced_next = 1'b0;
                            end
                            state_next = FS_HOUR;
                        end
                    end
                    FS_HOUR:
                    begin
                        if (sc == HOUR_BITS)
                        begin
                            dec = bcd8(sb & 8'h3F);
                            hour_next = dec[5:0];
                            if (par)
                            begin
                                synced_next = 1'b0;
                            end
                            dpar_next  = '0;
                            state_next = FS_DOM;
                        end
                    end
                    FS_DOM:
                    begin
                        if (sc == DOM_BITS)
                        begin
                            dec = bcd8(sb);
                            day_next   = dec[5:0];
                            dpar_next  = dpar_reg + {2'b00, par};
                            state_next = FS_DOW;
                        end
                    end
                    FS_DOW:
                    begin
                        if (sc == DOW_BITS)
                        begin
                            dpar_next  = dpar_reg + {2'b00, par};
                            state_next = FS_MONTH;
                        end
                    end
                    FS_MONTH:
                    begin
                        if (sc == MONTH_BITS)
                        begin
                            dec = bcd8(sb);
                            month_next = dec[4:0];
                            dpar_next  = dpar_reg + {2'b00, par};
                            state_next = FS_YEAR;
                        end
                    end
                    FS_YEAR:
                    begin
                        if (sc == YEAR_BITS)
                        begin
                            dec = bcd8(sb);
                            year_next  = CENTURY + {4'd0, dec};
                            dpar_next  = dpar_reg + {2'b00, par};
                            state_next = FS_DATEPAR;
                        end
                    end
                    FS_DATEPAR:
                    begin
                        dpar_next = dpar_reg + {2'b00, par};
                        if (dpar_next[0])
                        begin
                            synced_next = 1'b0;
                        end
                        state_next = FS_BULK;
                        done = 1'b1;
                    end
                    default:
                    begin
                        state_next = FS_BULK;
                    end
                endcase
                // a new field starts with an empty symbol
                if (state_next != fs || done)
                begin
                    sym_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sym_next   = sb;
                    count_next = sc;
                end
                event_next = done ? EV_FRAME : EV_BIT;
                bit_next   = tok.bit_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            synced_reg <= 1'b0;
            state_reg  <= FS_INIT;
            sym_reg    <= '0;
            count_reg  <= '0;
            dpar_reg   <= '0;
            skip_reg   <= 1'b0;
            summer_reg <= 1'b0;
            minute_reg <= '0;
            hour_reg   <= '0;
            day_reg    <= '0;
            month_reg  <= '0;
            year_reg   <= '0;
            event_reg  <= EV_NONE;
            bit_reg    <= 1'b0;
        end
        else
        begin
            if (tok_pop)
            begin
                valid_reg  <= 1'b1;
                synced_reg <= synced_next;
                state_reg  <= state_next;
                sym_reg    <= sym_next;
                count_reg  <= count_next;
                dpar_reg   <= dpar_next;
                skip_reg   <= skip_next;
                summer_reg <= summer_next;
                minute_reg <= minute_next;
                hour_reg   <= hour_next;
                day_reg    <= day_next;
                month_reg  <= month_next;
                year_reg   <= year_next;
                event_reg  <= event_next;
                bit_reg    <= bit_next;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/dcf77_pulse_and_frame_decoder.sv */
// Time code decoder for a long-wave receiver: give it one receiver level sample per
// transaction (nominally one every 10 ms) and it returns exactly one result for each,
// carrying an event (none, minute marker, bit taken, pulse error, frame complete),
// the classified bit and the last decoded minute, hour, day, month, year and
// summer-time flag together with the sync status. A sample is taken every clock cycle
// unless the classifier stalls; its result is registered when the frame decoder pops
// the classified pulse from the two-entry queue behind the pulse classifier. The
// classifier stalls only when that queue is full, so a stalled result output costs at
// most two further samples of headroom. Pulse and marker windows are set through the
// write port while no transaction is outstanding. The block does not enforce this.
module dcf77_pulse_and_frame_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     event_res,
    output logic                           bit_value,
    output logic [6:0]                     minute,
    output logic [5:0]                     hour,
    output logic [5:0]                     day,
    output logic [4:0]                     month,
    output logic [11:0]                    year,
    output logic                           summer_time,
    output logic                           in_sync,
    input  logic                           cfg_write_en,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dcf_pkg::*;

    token_t front_tok;
    token_t back_tok;
    logic   tok_push;
    logic   tok_pop;
    logic   fifo_full;
    logic   fifo_empty;

    dcf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .level        (level),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tok          (front_tok),
        .tok_push     (tok_push),
        .fifo_full    (fifo_full)
    );

    dcf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_push),
        .push_data (front_tok),
        .full      (fifo_full),
        .pop       (tok_pop),
        .pop_data  (back_tok),
        .empty     (fifo_empty)
    );

    dcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok         (back_tok),
        .fifo_empty  (fifo_empty),
        .tok_pop     (tok_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .bit_value   (bit_value),
        .minute      (minute),
        .hour        (hour),
        .day         (day),
        .month       (month),
        .year        (year),
        .summer_time (summer_time),
        .in_sync     (in_sync)
    );

endmodule

/* hdl/dcf_checker.sv */
module dcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_res,
    input logic        bit_value,
    input logic [11:0] year,
    input logic        in_sync
);
    import dcf_pkg::*;

    // only the five defined event codes ever appear
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res <= EV_FRAME))
        else $error("undefined event code");

    // bit value only carries meaning with a taken bit or a frame end
    a_bit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_BIT && event_res != EV_FRAME) |-> !bit_value)
        else $error("bit value set without a taken bit");

    // a minute marker always leaves the decoder in sync
    a_marker_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_MARKER) |-> in_sync)
        else $error("marker without sync");

    // a pulse error always drops sync
    a_error_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_ERROR) |-> !in_sync)
        else $error("pulse error kept sync");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(year)))
        else $error("stalled result changed");

endmodule

bind dcf77_pulse_and_frame_decoder dcf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .bit_value (bit_value),
    .year      (year),
    .in_sync   (in_sync)
);

/* test/dcf77_pulse_and_frame_decoder_tb.sv */
module dcf77_pulse_and_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [2:0]  ev;
        logic        bit_v;
        logic [6:0]  minute;
        logic [5:0]  hour;
        logic [5:0]  day;
        logic [4:0]  month;
        logic [11:0] year;
        logic        summer;
        logic        sync;
    } dcf_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  level = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            event_res;
    logic                  bit_value;
    logic [6:0]            minute;
    logic [5:0]            hour;
    logic [5:0]            day;
    logic [4:0]            month;
    logic [11:0]           year;
    logic                  summer_time;
    logic                  in_sync;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        level_q[$];
    dcf_result_t decode_q[$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_no = 0;
    int          low_slack = 2;

    // mirror of the window registers
    logic [7:0] zero_lo, zero_hi, one_lo, one_hi, gap_lo, gap_hi;

    // decoder state as seen by the predictor
    logic [7:0]  high_run;
    logic [7:0]  since_rise;
    logic        locked;
    logic        skip_next;
    logic        summer_p;
    logic [3:0]  field_state;
    logic [3:0]  shift_cnt;
    logic [7:0]  shift_bits;
    logic [2:0]  dpar_p;
    int unsigned minute_p, hour_p, day_p, month_p, year_p;

    dcf77_pulse_and_frame_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .level        (level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .bit_value    (bit_value),
        .minute       (minute),
        .hour         (hour),
        .day          (day),
        .month        (month),
        .year         (year),
        .summer_time  (summer_time),
        .in_sync      (in_sync),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned bcd_value(input logic [7:0] s);
        return s[3:0] + 10 * s[7:4];
    endfunction

    function automatic void reset_predictor();
        zero_lo = ZERO_MIN_RST;
        zero_hi = ZERO_MAX_RST;
        one_lo = ONE_MIN_RST;
        one_hi = ONE_MAX_RST;
        gap_lo = GAP_MIN_RST;
        gap_hi = GAP_MAX_RST;
        high_run = '0;
        since_rise = '0;
        locked = 1'b0;
        skip_next = 1'b0;
        summer_p = 1'b0;
        field_state = FS_INIT;
        shift_cnt = '0;
        shift_bits = '0;
        dpar_p = '0;
        minute_p = 0;
        hour_p = 0;
        day_p = 0;
        month_p = 0;
        year_p = 0;
    endfunction

    function automatic void open_field(input logic [3:0] st);
        field_state = st;
        shift_bits = '0;
        shift_cnt = '0;
    endfunction

    // shifts one bit into the current field, returns 1 on the date parity bit
    function automatic bit store_frame_bit(input logic b);
        bit done;
        done = 1'b0;
        if (field_state == FS_INIT)
            open_field(FS_BULK);
        // bulk bits past the eighth are counted only
        if (b && shift_cnt < 4'd8)
            shift_bits[shift_cnt[2:0]] = 1'b1;
        if (shift_cnt < COUNT_LIMIT)
            shift_cnt = shift_cnt + 4'd1;
        case (field_state)
            FS_BULK:
                if (shift_cnt == BULK_BITS)
                    open_field(FS_STATUS);
            FS_STATUS:
                if (shift_cnt == STATUS_BITS)
                begin
                    if (shift_bits[SUMMER_BIT] && !shift_bits[WINTER_BIT])
                        summer_p = 1'b1;
                    else if (shift_bits[WINTER_BIT] && !shift_bits[SUMMER_BIT])
                        summer_p = 1'b0;
                    open_field(FS_MINUTE);
                end
            FS_MINUTE:
                if (shift_cnt == MINUTE_BITS)
                begin
                    minute_p = bcd_value(shift_bits & 8'h7F);
                    if (^shift_bits)
                        locked = 1'b0;
                    open_field(FS_HOUR);
                end
            FS_HOUR:
                if (shift_cnt == HOUR_BITS)
                begin
                    hour_p = bcd_value(shift_bits & 8'h3F);
                    if (^shift_bits)
                        locked = 1'b0;
                    dpar_p = '0;
                    open_field(FS_DOM);
                end
            FS_DOM:
                if (shift_cnt == DOM_BITS)
                begin
                    day_p = bcd_value(shift_bits);
                    dpar_p = dpar_p + {2'b00, ^shift_bits};
                    open_field(FS_DOW);
                end
            FS_DOW:
                if (shift_cnt == DOW_BITS)
                begin
                    dpar_p = dpar_p + {2'b00, ^shift_bits};
                    open_field(FS_MONTH);
                end
            FS_MONTH:
                if (shift_cnt == MONTH_BITS)
                begin
                    month_p = bcd_value(shift_bits);
                    dpar_p = dpar_p + {2'b00, ^shift_bits};
                    open_field(FS_YEAR);
                end
            FS_YEAR:
                if (shift_cnt == YEAR_BITS)
                begin
                    year_p = CENTURY + bcd_value(shift_bits);
                    dpar_p = dpar_p + {2'b00, ^shift_bits};
                    open_field(FS_DATEPAR);
                end
            FS_DATEPAR:
            begin
                dpar_p = dpar_p + {2'b00, ^shift_bits};
                if (dpar_p[0])
                    locked = 1'b0;
                open_field(FS_BULK);
                done = 1'b1;
            end
            default:
                open_field(FS_BULK);
        endcase
        return done;
    endfunction

    function automatic dcf_result_t decode_sample(input logic lvl);
        dcf_result_t r;
        logic        ok;
        logic        b;
        r.ev = EV_NONE;
        r.bit_v = 1'b0;
        if (lvl)
        begin
            if (high_run == 8'd0)
            begin
                if (since_rise >= gap_lo && since_rise <= gap_hi)
                begin
                    locked = 1'b1;
                    field_state = FS_INIT;
                    skip_next = 1'b1;
                    r.ev = EV_MARKER;
                end
                since_rise = '0;
            end
            if (high_run < PULSE_LIMIT)
                high_run = high_run + 8'd1;
        end
        else
        begin
            ok = 1'b0;
            b = 1'b0;
            // the bit 0 window wins where the two overlap
            if (high_run >= zero_lo && high_run <= zero_hi)
                ok = 1'b1;
            else if (high_run >= one_lo && high_run <= one_hi)
            begin
                ok = 1'b1;
                b = 1'b1;
            end
            else if (high_run != 8'd0)
            begin
                locked = 1'b0;
                r.ev = EV_ERROR;
            end
            if (ok && locked)
            begin
                if (skip_next)
                    skip_next = 1'b0;
                else
                begin
                    r.ev = store_frame_bit(b) ? EV_FRAME : EV_BIT;
                    r.bit_v = b;
                end
            end
            high_run = '0;
        end
        if (since_rise < GAP_LIMIT)
            since_rise = since_rise + 8'd1;
        r.minute = minute_p[6:0];
        r.hour = hour_p[5:0];
        r.day = day_p[5:0];
        r.month = month_p[4:0];
        r.year = year_p[11:0];
        r.summer = summer_p;
        r.sync = locked;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            level     <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (level_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    level    <= level_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // monitor: input side first so a same-edge result still finds its expectation
    always @(posedge clk or negedge rst_n)
    begin
        dcf_result_t want;
        if (!rst_n)
            reset_predictor();
        else
        begin
            if (in_valid && !in_stall)
                decode_q.push_back(decode_sample(level));
            if (out_valid && !out_stall)
            begin
                if (decode_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $error("result transaction with nothing outstanding");
                end
                else
                begin
                    want = decode_q.pop_front();
                    check_field("event_res", want.ev, event_res);
                    check_field("bit_value", want.bit_v, bit_value);
                    check_field("minute", want.minute, minute);
                    check_field("hour", want.hour, hour);
                    check_field("day", want.day, day);
                    check_field("month", want.month, month);
                    check_field("year", want.year, year);
                    check_field("summer_time", want.summer, summer_time);
                    check_field("in_sync", want.sync, in_sync);
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (level_q.size() != 0 || in_valid || decode_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic start_phase();
        case (phase_no % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 59;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 59;
            end
            default:
            begin
                send_idle_pct = 22;
                recv_stall_pct = 22;
            end
        endcase
        phase_no++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            CFG_ZERO_MIN: zero_lo = val;
            CFG_ZERO_MAX: zero_hi = val;
            CFG_ONE_MIN:  one_lo = val;
            CFG_ONE_MAX:  one_hi = val;
            CFG_GAP_MIN:  gap_lo = val;
            CFG_GAP_MAX:  gap_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [7:0] z0, input logic [7:0] z1,
                               input logic [7:0] o0, input logic [7:0] o1,
                               input logic [7:0] g0, input logic [7:0] g1,
                               input bit spare);
        write_reg(CFG_ZERO_MIN, z0);
        write_reg(CFG_ZERO_MAX, z1);
        write_reg(CFG_ONE_MIN, o0);
        write_reg(CFG_ONE_MAX, o1);
        write_reg(CFG_GAP_MIN, g0);
        write_reg(CFG_GAP_MAX, g1);
        // unmapped indexes must leave the windows alone
        if (spare)
        begin
            write_reg(CFG_SPARE_A, 8'($urandom));
            write_reg(CFG_SPARE_B, 8'($urandom));
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic add_run(input logic v, input int n);
        repeat (n) level_q.push_back(v);
    endtask

    function automatic int pulse_len(input bit b);
        int lo;
        int hi;
        lo = b ? one_lo : zero_lo;
        hi = b ? one_hi : zero_hi;
        if (lo > hi)
            return $urandom_range(4, 1);
        if (lo < 1)
            lo = 1;
        if (hi < lo)
            hi = lo;
        return $urandom_range(hi, lo);
    endfunction

    // one pulse plus its low tail; a marker tail puts the next rising edge in the window
    task automatic add_pulse(input bit b, input bit to_marker);
        int h;
        int lo_min;
        int lo_max;
        h = pulse_len(b);
        if (to_marker)
        begin
            lo_min = int'(gap_lo) - h;
            lo_max = int'(gap_hi) - h;
        end
        else
        begin
            lo_min = 1;
            lo_max = int'(gap_lo) - h - 1;
            if (lo_max > lo_min + low_slack)
                lo_max = lo_min + low_slack;
        end
        if (lo_min < 1)
            lo_min = 1;
        if (lo_max < lo_min)
            lo_max = lo_min;
        add_run(1'b1, h);
        add_run(1'b0, $urandom_range(lo_max, lo_min));
    endtask

    // marker pulse, then up to 58 frame bits; the last bit's tail leads to a marker
    task automatic add_frame(input int keep, input bit spoil);
        logic [57:0] fb;
        logic [6:0]  mins;
        logic [5:0]  hrs;
        logic [21:0] date;
        int          i;
        fb = {$urandom, $urandom};
        mins = fb[26:20];
        fb[27] = ^mins;
        hrs = fb[33:28];
        fb[34] = ^hrs;
        date = fb[56:35];
        fb[57] = ^date;
        if (spoil)
        begin
            i = $urandom_range(57, 20);
            fb[i] = ~fb[i];
        end
        add_pulse($urandom_range(1, 0), keep == 0);
        for (i = 0; i < keep; i++)
            add_pulse(fb[i], i == keep - 1);
    endtask

    task automatic add_noise(input int runs, input int longest);
        logic v;
        int   n;
        int   i;
        v = $urandom_range(1, 0);
        for (i = 0; i < runs; i++)
        begin
            n = ($urandom_range(7, 0) == 0) ? $urandom_range(longest, 1) : $urandom_range(6, 1);
            add_run(v, n);
            v = ~v;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: marker, skipped bit, both bit values, bad pulse, pulse out of sync
        wait_idle();
        start_phase();
        set_windows(8'd1, 8'd1, 8'd2, 8'd2, 8'd8, 8'd9, 1'b0);
        @(negedge clk);
        add_run(1'b0, 2);
        add_run(1'b1, 1);
        add_run(1'b0, 7);
        add_run(1'b1, 2);
        add_run(1'b0, 2);
        add_run(1'b1, 1);
        add_run(1'b0, 2);
        add_run(1'b1, 2);
        add_run(1'b0, 2);
        add_run(1'b1, 3);
        add_run(1'b0, 1);
        add_run(1'b1, 1);
        add_run(1'b0, 1);

        wait_idle();
        start_phase();
        set_windows(8'd1, 8'd1, 8'd2, 8'd2, 8'd9, 8'd10, 1'b0);
        @(negedge clk);
        low_slack = 2;
        add_pulse($urandom_range(1, 0), 1'b1);
        add_frame(58, 1'b0);

        wait_idle();
        start_phase();
        set_windows(8'd2, 8'd3, 8'd4, 8'd5, 8'd14, 8'd16, 1'b1);
        @(negedge clk);
        low_slack = 3;
        add_pulse($urandom_range(1, 0), 1'b1);
        add_noise(20, 15);
        add_pulse($urandom_range(1, 0), 1'b1);
        add_frame(58, 1'b1);

        // a zero lower bound makes every idle low sample a bit 0
        wait_idle();
        start_phase();
        set_windows(8'd0, 8'd1, 8'd2, 8'd3, 8'd12, 8'd14, 1'b0);
        @(negedge clk);
        low_slack = 3;
        add_pulse($urandom_range(1, 0), 1'b1);
        add_frame(24, 1'b0);
        add_noise(20, 12);

        // both counters saturate; the marker needs a saturated gap
        wait_idle();
        start_phase();
        set_windows(8'd255, 8'd255, 8'd0, 8'd254, 8'd250, 8'd250, 1'b1);
        @(negedge clk);
        add_run(1'b1, 258);
        add_run(1'b0, 2);
        add_run(1'b1, 2);
        add_run(1'b0, 1);
        add_noise(10, 8);

        // empty bit 0 window, every rising edge a marker
        wait_idle();
        start_phase();
        set_windows(8'd6, 8'd3, 8'd1, 8'd2, 8'd0, 8'd250, 1'b0);
        @(negedge clk);
        add_noise(30, 10);

        // overlapping windows
        wait_idle();
        start_phase();
        set_windows(8'd1, 8'd3, 8'd2, 8'd4, 8'd12, 8'd13, 1'b0);
        @(negedge clk);
        low_slack = 3;
        add_pulse($urandom_range(1, 0), 1'b1);
        add_frame(20, 1'b0);

        wait_idle();
        start_phase();
        set_windows(ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST,
                    GAP_MIN_RST, GAP_MAX_RST, 1'b1);
        @(negedge clk);
        low_slack = 12;
        add_pulse($urandom_range(1, 0), 1'b1);
        add_frame(2, 1'b0);

        wait_idle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
